/* design/pps_pkg.sv */
package pps_pkg;

    localparam int SLOTS_DEF = 16;

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [31:0] TIME_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  slot_index;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
        logic [7:0]  priority_level;
    } t_in;

    typedef struct packed {
        logic        ran_valid;
        logic [3:0]  ran_slot;
        logic        new_segment;
        logic [31:0] tick_start;
        logic        slot_finished;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic        all_done;
    } t_out;

    // Best candidate so far, handed from cell to cell along the chain.
    typedef struct packed {
        logic        found;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic        last_one;
        logic [1:0]  pend_cnt;
    } t_best;

    // Broadcast commands from the controller to every cell.
    typedef struct packed {
        logic load;
        logic clear;
        logic dec;
    } t_cell_ctl;

endpackage

/* design/pps_cell.sv */
module pps_cell #(
    parameter int CELL_ID = 0,
    parameter int SLOT_W  = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pps_pkg::t_cell_ctl    i_ctl,
    input  pps_pkg::t_in          i_load,
    input  logic [SLOT_W-1:0]     i_dec_idx,
    input  logic [31:0]           i_now,
    input  pps_pkg::t_best        i_best,
    input  logic [SLOT_W-1:0]     i_best_idx,
    output pps_pkg::t_best        o_best,
    output logic [SLOT_W-1:0]     o_best_idx
);
    import pps_pkg::*;

    logic        r_loaded;
    logic        r_done;
    logic [15:0] r_arrival;
    logic [15:0] r_burst;
    logic [15:0] r_remaining;
    logic [7:0]  r_prio;

    t_best             r_best;
    logic [SLOT_W-1:0] r_best_idx;
    t_best             n_best;
    logic [SLOT_W-1:0] n_best_idx;

    logic load_hit;
    logic dec_hit;
    logic pending;
    logic eligible;
    logic take;

    assign load_hit = i_ctl.load && (32'(i_load.slot_index) == CELL_ID);
    assign dec_hit  = i_ctl.dec && (i_dec_idx == SLOT_W'(CELL_ID));
    assign pending  = r_loaded && !r_done;
    assign eligible = pending && ({16'b0, r_arrival} <= i_now);
    assign take     = eligible && (!i_best.found || (r_prio < i_best.prio));

    always_comb begin
        n_best     = i_best;
        n_best_idx = i_best_idx;
        if (take) begin
            n_best.found    = 1'b1;
            n_best.prio     = r_prio;
            n_best.arrival  = r_arrival;
            n_best.burst    = r_burst;
            n_best.last_one = (r_remaining == 16'd1);
            n_best_idx      = SLOT_W'(CELL_ID);
        end
        // Count of unfinished slots, held at two since only zero and one matter.
        if (pending && (i_best.pend_cnt != 2'd2)) begin
            n_best.pend_cnt = i_best.pend_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
        end else if (i_ctl.clear) begin
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
        end else if (load_hit) begin
            r_loaded <= 1'b1;
            r_done   <= (i_load.burst_length == 16'd0);
        end else if (dec_hit && (r_remaining == 16'd1)) begin
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_hit) begin
            r_arrival   <= i_load.arrival_time;
            r_burst     <= i_load.burst_length;
            r_remaining <= i_load.burst_length;
            r_prio      <= i_load.priority_level;
        end else if (dec_hit) begin
            r_remaining <= r_remaining - 16'd1;
        end
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
    end

    assign o_best     = r_best;
    assign o_best_idx = r_best_idx;

endmodule

/* design/preemptive_priority_scheduler.sv */
// Preemptive priority scheduler over a row of SLOTS process slots.
// Input channel: i_in_valid / o_in_stall carry one word of type t_in.
// A load fills one slot, a clear empties the table and sets time to zero;
// both take effect at acceptance and give no result. Operation 3 is ignored.
// A tick word gives exactly one result word on o_out_valid / i_out_stall.
// Each slot lives in a cell; a tick sends the best-candidate word along the
// chain, one cell per cycle, so a tick keeps the input stalled through its
// scan and until its result is registered in the output register.
// A new tick is therefore taken only once the previous one is through.
// Loads and clears are taken at one word per cycle while no tick stalls the input.
// A held result does not block loads or clears, nor the acceptance and scan
// of the next tick; that tick waits at the end of its scan until the output
// register is free. A stalled result word holds its value.
// Reset empties every slot, zeroes time, forgets the previous pick and
// drops any pending result.
module preemptive_priority_scheduler #(
    parameter int SLOTS = pps_pkg::SLOTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  pps_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output pps_pkg::t_out o_out
);
    import pps_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [SLOT_W-1:0] r_cnt;
    logic [31:0]       r_now;
    logic [31:0]       n_now;
    logic              r_last_valid;
    logic [SLOT_W-1:0] r_last_idx;
    logic              r_out_valid;
    t_out              r_out;
    t_out              n_out;

    t_best             w_best [SLOTS+1];
    logic [SLOT_W-1:0] w_idx  [SLOTS+1];
    t_cell_ctl         cell_ctl;

    logic        in_acc;
    logic        finish;
    logic        out_free;
    logic [31:0] now_inc;
    logic [31:0] tat;
    t_best       best;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign finish   = (r_state == ST_DONE) && out_free;
    assign best     = w_best[SLOTS];
    assign now_inc  = (r_now == TIME_MAX) ? r_now : r_now + 32'd1;
    assign tat      = now_inc - {16'b0, best.arrival};

    assign cell_ctl.load  = in_acc && (i_in.operation == OP_LOAD);
    assign cell_ctl.clear = in_acc && (i_in.operation == OP_CLEAR);
    assign cell_ctl.dec   = finish && best.found;

    assign w_best[0] = '0;
    assign w_idx[0]  = '0;

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        pps_cell #(
            .CELL_ID (k),
            .SLOT_W  (SLOT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (cell_ctl),
            .i_load     (i_in),
            .i_dec_idx  (w_idx[SLOTS]),
            .i_now      (r_now),
            .i_best     (w_best[k]),
            .i_best_idx (w_idx[k]),
            .o_best     (w_best[k+1]),
            .o_best_idx (w_idx[k+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in.operation == OP_TICK)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == SLOT_W'(SLOTS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_now = r_now;
        if (cell_ctl.clear) begin
            n_now = '0;
        end else if (finish) begin
            n_now = now_inc;
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.tick_start = r_now;
        if (best.found) begin
            n_out.ran_valid   = 1'b1;
            n_out.ran_slot    = 4'(w_idx[SLOTS]);
            n_out.new_segment = !r_last_valid || (r_last_idx != w_idx[SLOTS]);
            if (best.last_one) begin
                n_out.slot_finished = 1'b1;
                n_out.turnaround    = tat;
                n_out.waiting       = (tat >= {16'b0, best.burst})
                                    ? tat - {16'b0, best.burst} : 32'd0;
            end
        end
        n_out.all_done = (best.pend_cnt == 2'd0)
                      || ((best.pend_cnt == 2'd1) && best.found && best.last_one);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_now        <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_now   <= n_now;
            if (r_state == ST_SCAN) begin
                r_cnt <= r_cnt + SLOT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (cell_ctl.clear) begin
                r_last_valid <= 1'b0;
            end else if (cell_ctl.dec) begin
                r_last_valid <= 1'b1;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cell_ctl.dec) begin
            r_last_idx <= w_idx[SLOTS];
        end
        if (finish) begin
            r_out <= n_out;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

/* design/pps_chk.sv */
module pps_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input pps_pkg::t_in  i_in,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input pps_pkg::t_out o_out
);
    import pps_pkg::*;

    // A held result word keeps its value until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result word changed while stalled");

    // An idle tick reports no slot and no completion.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.ran_valid |->
            (o_out.ran_slot == 4'd0) && !o_out.new_segment && !o_out.slot_finished
            && (o_out.turnaround == 32'd0) && (o_out.waiting == 32'd0))
        else $error("idle tick carries slot data");

    // A completion implies that a slot ran and that waiting never exceeds turnaround.
    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.slot_finished |->
            o_out.ran_valid && (o_out.waiting <= o_out.turnaround))
        else $error("inconsistent completion word");

    // An accepted tick holds the input side off while its scan runs.
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in.operation == OP_TICK) |=> o_in_stall)
        else $error("tick did not start a scan");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result pending after reset");

endmodule

bind preemptive_priority_scheduler pps_chk u_pps_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);
